FILE: design/bnr_pkg.sv
// Package for the bus node roster table: sizes, codes, payload and slot types.
// Used by every module of the block; depends on nothing.
package bnr_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;
	localparam int POS_W = 4;
	localparam int SEEN_W = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

	localparam logic [7:0] ADDR_NONE = 8'h00;
	localparam logic [7:0] ADDR_BCAST = 8'hFF;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		OP_ENROLL     = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_FIND       = 3'd2,
		OP_NTH        = 3'd3,
		OP_NEXT_EN    = 3'd4,
		OP_CLEAR      = 3'd5
	} op_e;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_DUP       = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_BAD_ADDR  = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [7:0]       node_addr;
		logic [31:0]      node_class;
		logic [7:0]       node_flags;
		logic [POS_W-1:0] position;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [7:0]  entry_addr;
		logic [31:0] entry_class;
		logic [7:0]  entry_flags;
		logic [4:0]  occupied;
	} out_t;

	typedef struct packed {
		logic [7:0]  addr;
		logic [31:0] cls;
		logic [7:0]  flags;
	} slot_t;

	// Update request from the engine to the slot store.
	typedef struct packed {
		logic  wr;
		logic  drop;
		logic  clear;
		idx_t  idx;
		slot_t data;
	} store_cmd_t;

	function automatic idx_t idx_inc(idx_t i);
		if (i == IDX_W'(SLOTS - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

endpackage

FILE: design/bnr_slot_store.sv
// Slot store: one synchronous memory holding address, class and flags per slot,
// occupancy bits in flip-flops and the occupied count. Depends on bnr_pkg.
module bnr_slot_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bnr_pkg::idx_t            rd_idx,
	output bnr_pkg::slot_t           rdata,
	output logic [bnr_pkg::SLOTS-1:0] occ_bits,
	input  bnr_pkg::store_cmd_t      cmd,
	output logic [bnr_pkg::CNT_W-1:0] cnt_next
);
	import bnr_pkg::*;

	slot_t             mem [SLOTS];
	slot_t             rdata_q;
	logic [SLOTS-1:0]  occ_q;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.idx] <= cmd.data;
		end
		rdata_q <= mem[rd_idx];
	end

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.clear) begin
			cnt_next = '0;
		end else if (cmd.wr) begin
			cnt_next = cnt_q + 1'b1;
		end else if (cmd.drop) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	// A slot is free exactly when its occupancy bit is low, so the stored
	// address is only looked at for occupied slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
			if (cmd.clear) begin
				occ_q <= '0;
			end else if (cmd.wr) begin
				occ_q[cmd.idx] <= 1'b1;
			end else if (cmd.drop) begin
				occ_q[cmd.idx] <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign occ_bits = occ_q;

endmodule

FILE: design/bnr_engine.sv
// Command engine: takes one command word, sweeps the slot store one slot per
// cycle, then issues the store update and the result. Depends on bnr_pkg.
module bnr_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  bnr_pkg::in_t             cmd,
	input  logic                     out_free,
	output logic                     res_valid,
	output bnr_pkg::out_t            res,
	output bnr_pkg::idx_t            rd_idx,
	input  bnr_pkg::slot_t           rdata,
	input  logic [bnr_pkg::SLOTS-1:0] occ_bits,
	output bnr_pkg::store_cmd_t      st_cmd,
	input  logic [bnr_pkg::CNT_W-1:0] cnt_next
);
	import bnr_pkg::*;

	localparam idx_t LAST = IDX_W'(SLOTS - 1);

	state_t            state_q, state_d;
	in_t               req_q;
	idx_t              k_q, rd_idx_q, idx_s1, free_idx_q, match_idx_q, cursor_q;
	logic              eval_s1;
	logic              dup_q, free_ok_q, hit_q;
	slot_t             ent_q;
	logic [SEEN_W-1:0] seen_q;
	logic              accept, needs_scan, bad_addr;
	logic              slot_v, addr_match, nth_take, next_take;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign bad_addr = (cmd.node_addr == ADDR_NONE) || (cmd.node_addr == ADDR_BCAST);
	assign rd_idx = rd_idx_q;

	always_comb begin
		needs_scan = 1'b0;
		if (cmd.op inside {OP_UNREGISTER, OP_FIND, OP_NTH, OP_NEXT_EN}) begin
			needs_scan = 1'b1;
		end else if (cmd.op == OP_ENROLL) begin
			needs_scan = !bad_addr;
		end
	end

	// Per-slot evaluation, in the cycle after the read address is presented.
	assign slot_v = occ_bits[idx_s1];
	assign addr_match = slot_v && (rdata.addr == req_q.node_addr);
	assign nth_take = eval_s1 && (req_q.op == OP_NTH) && !hit_q && slot_v
		&& (seen_q == SEEN_W'(req_q.position));
	assign next_take = eval_s1 && (req_q.op == OP_NEXT_EN) && !hit_q && slot_v
		&& rdata.flags[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = needs_scan ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (k_q == LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
			cursor_q <= '0;
		end else begin
			eval_s1 <= (state_q == S_SCAN);
			if (next_take) begin
				cursor_q <= idx_inc(idx_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			req_q <= cmd;
			k_q <= '0;
			rd_idx_q <= (cmd.op == OP_NEXT_EN) ? cursor_q : '0;
			dup_q <= 1'b0;
			free_ok_q <= 1'b0;
			free_idx_q <= '0;
			hit_q <= 1'b0;
			match_idx_q <= '0;
			ent_q <= '0;
			seen_q <= '0;
		end else begin
			if (state_q == S_SCAN) begin
				k_q <= k_q + 1'b1;
				rd_idx_q <= idx_inc(rd_idx_q);
			end
			if (eval_s1) begin
				case (req_q.op)
					OP_ENROLL: begin
						if (addr_match) begin
							dup_q <= 1'b1;
						end
						if (!slot_v && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					OP_UNREGISTER, OP_FIND: begin
						if (addr_match && !hit_q) begin
							hit_q <= 1'b1;
							ent_q <= rdata;
							match_idx_q <= idx_s1;
						end
					end
					OP_NTH: begin
						if (nth_take) begin
							hit_q <= 1'b1;
							ent_q <= rdata;
						end else if (slot_v && !hit_q) begin
							seen_q <= seen_q + 1'b1;
						end
					end
					OP_NEXT_EN: begin
						if (next_take) begin
							hit_q <= 1'b1;
							ent_q <= rdata;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The store update is issued on the same edge as the result, so the next
	// command's sweep, which can only start once the engine is back in idle, sees it.
	always_comb begin
		logic take;
		take = res_valid;
		st_cmd = '0;
		st_cmd.data.addr = req_q.node_addr;
		st_cmd.data.cls = req_q.node_class;
		st_cmd.data.flags = req_q.node_flags;
		res = '0;
		res.status = STAT_OK;
		case (req_q.op)
			OP_ENROLL: begin
				if ((req_q.node_addr == ADDR_NONE) || (req_q.node_addr == ADDR_BCAST)) begin
					res.status = STAT_BAD_ADDR;
				end else if (dup_q) begin
					res.status = STAT_DUP;
				end else if (free_ok_q) begin
					st_cmd.wr = take;
					st_cmd.idx = free_idx_q;
				end else begin
					res.status = STAT_FULL;
				end
			end
			OP_UNREGISTER: begin
				if (hit_q) begin
					st_cmd.drop = take;
					st_cmd.idx = match_idx_q;
				end else begin
					res.status = STAT_NOT_FOUND;
				end
			end
			OP_FIND, OP_NTH, OP_NEXT_EN: begin
				if (hit_q) begin
					res.hit = 1'b1;
					res.entry_addr = ent_q.addr;
					res.entry_class = ent_q.cls;
					res.entry_flags = ent_q.flags;
				end else begin
					res.status = STAT_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				st_cmd.clear = take;
			end
			default: begin
			end
		endcase
		res.occupied = cnt_next[4:0];
	end

endmodule

FILE: design/bus_node_roster_table.sv
// Bus node roster table. A scanning command (register with a legal address,
// unregister, find, nth occupied, next enabled) sweeps the slot memory before
// its result word is registered; other commands go straight to the result.
// One command at a time: a new word is taken only after the last result word
// has gone to the output register. The sweep reads one slot per cycle.
// Reset clears the occupancy bits, the occupied count and the poll cursor at once.
module bus_node_roster_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  bnr_pkg::in_t  cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bnr_pkg::out_t rsp
);
	import bnr_pkg::*;

	logic             out_free, res_valid;
	out_t             res, rsp_q;
	logic             rsp_valid_q;
	idx_t             rd_idx;
	slot_t            rdata;
	logic [SLOTS-1:0] occ_bits;
	store_cmd_t       st_cmd;
	logic [CNT_W-1:0] cnt_next;

	bnr_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rdata    (rdata),
		.occ_bits (occ_bits),
		.cmd      (st_cmd),
		.cnt_next (cnt_next)
	);

	bnr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.rd_idx    (rd_idx),
		.rdata     (rdata),
		.occ_bits  (occ_bits),
		.st_cmd    (st_cmd),
		.cnt_next  (cnt_next)
	);

	// Output register: holds a finished word until the consumer takes it.
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: design/bnr_checker.sv
// Port-level checks for the bus node roster table, bound to the top level.
// Depends on bnr_pkg.
module bnr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bnr_pkg::out_t rsp
);
	import bnr_pkg::*;

	// A result word waiting for the consumer holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// The block works on one command at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in flight");

	// A returned entry always comes with success and a legal stored address.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.status == STAT_OK
			&& rsp.entry_addr != ADDR_NONE && rsp.entry_addr != ADDR_BCAST)
		else $error("hit with bad status or address");

	// Without a returned entry the entry fields are all zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.entry_addr == '0 && rsp.entry_class == '0
			&& rsp.entry_flags == '0)
		else $error("entry fields set without hit");

endmodule

bind bus_node_roster_table bnr_checker u_bnr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

FILE: test/testbench.sv
// Testbench for bus_node_roster_table: random and directed command words, with a
// scoreboard class that predicts each reply word. Depends on bnr_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
	import bnr_pkg::*;

	// Op codes the block has no meaning for; it must answer them and change nothing.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int RANDOM_WORDS = 1850;

	class roster_scoreboard;
		logic [7:0]  tab_addr[SLOTS];
		logic [31:0] tab_class[SLOTS];
		logic [7:0]  tab_flags[SLOTS];
		int          poll_at;
		int          fails;
		out_t        replies_due[$];

		function new();
			foreach (tab_addr[i]) begin
				tab_addr[i] = ADDR_NONE;
				tab_class[i] = '0;
				tab_flags[i] = '0;
			end
			poll_at = 0;
			fails = 0;
		endfunction

		function int slot_of(logic [7:0] a);
			if (a == ADDR_NONE) begin
				return -1;
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (tab_addr[i] == a) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void note_command(in_t c);
			out_t    want;
			status_e st;
			int      found;
			int      seen;
			int      n;
			int      i;
			st = STAT_OK;
			found = -1;
			seen = 0;
			n = 0;
			case (c.op)
				OP_ENROLL: begin
					if (c.node_addr == ADDR_NONE || c.node_addr == ADDR_BCAST) begin
						st = STAT_BAD_ADDR;
					end else if (slot_of(c.node_addr) >= 0) begin
						st = STAT_DUP;
					end else begin
						st = STAT_FULL;
						for (i = 0; i < SLOTS; i++) begin
							if (tab_addr[i] == ADDR_NONE) begin
								tab_addr[i] = c.node_addr;
								tab_class[i] = c.node_class;
								tab_flags[i] = c.node_flags;
								st = STAT_OK;
								break;
							end
						end
					end
				end
				OP_UNREGISTER: begin
					i = slot_of(c.node_addr);
					if (i >= 0) begin
						tab_addr[i] = ADDR_NONE;
					end else begin
						st = STAT_NOT_FOUND;
					end
				end
				OP_FIND: begin
					found = slot_of(c.node_addr);
					if (found < 0) begin
						st = STAT_NOT_FOUND;
					end
				end
				OP_NTH: begin
					for (i = 0; i < SLOTS; i++) begin
						if (tab_addr[i] != ADDR_NONE) begin
							if (seen == c.position) begin
								found = i;
								break;
							end
							seen++;
						end
					end
					if (found < 0) begin
						st = STAT_NOT_FOUND;
					end
				end
				OP_NEXT_EN: begin
					// Round robin from the cursor; the cursor moves only on a hit.
					for (int k = 0; k < SLOTS; k++) begin
						i = (poll_at + k) % SLOTS;
						if (tab_addr[i] != ADDR_NONE && tab_flags[i][0]) begin
							found = i;
							poll_at = (i + 1) % SLOTS;
							break;
						end
					end
					if (found < 0) begin
						st = STAT_NOT_FOUND;
					end
				end
				OP_CLEAR: begin
					for (i = 0; i < SLOTS; i++) begin
						tab_addr[i] = ADDR_NONE;
					end
				end
				default: begin
				end
			endcase
			want = '0;
			want.status = st;
			if (found >= 0) begin
				want.hit = 1'b1;
				want.entry_addr = tab_addr[found];
				want.entry_class = tab_class[found];
				want.entry_flags = tab_flags[found];
			end
			for (i = 0; i < SLOTS; i++) begin
				if (tab_addr[i] != ADDR_NONE) begin
					n++;
				end
			end
			want.occupied = 5'(n);
			replies_due.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_reply(out_t got);
			out_t want;
			if (replies_due.size() == 0) begin
				$error("reply word with no command pending");
				fails++;
				return;
			end
			want = replies_due.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("hit", want.hit, got.hit);
			compare_field("entry_addr", want.entry_addr, got.entry_addr);
			compare_field("entry_class", want.entry_class, got.entry_class);
			compare_field("entry_flags", want.entry_flags, got.entry_flags);
			compare_field("occupied", want.occupied, got.occupied);
		endfunction

		function int pending();
			return replies_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	in_t  cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_t rsp;

	roster_scoreboard roster = new();
	int         burst_left = 0;
	int         rx_tick = 0;
	logic [1:0] rx_mode = 2'd0;

	bus_node_roster_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("bus_node_roster_table verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			roster.note_command(cmd);
		end
		if (rsp_valid && rsp_ready) begin
			roster.check_reply(rsp);
		end
	end

	// The receiver switches between always ready, random stalls and a fixed duty cycle.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick[8:0] == 9'd0) begin
			rx_mode <= 2'($urandom_range(0, 3));
		end
		case (rx_mode)
			2'd0: rsp_ready <= 1'b1;
			2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
			2'd2: rsp_ready <= ((rx_tick % 7) < 4);
			default: rsp_ready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	function automatic in_t cmd_word(logic [2:0] op, logic [7:0] addr, logic [31:0] cls,
			logic [7:0] flags, logic [3:0] pos);
		in_t w;
		w.op = op;
		w.node_addr = addr;
		w.node_class = cls;
		w.node_flags = flags;
		w.position = pos;
		return w;
	endfunction

	function automatic in_t random_word();
		in_t w;
		int  pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			w.op = OP_ENROLL;
		end else if (pick < 47) begin
			w.op = OP_UNREGISTER;
		end else if (pick < 60) begin
			w.op = OP_FIND;
		end else if (pick < 72) begin
			w.op = OP_NTH;
		end else if (pick < 93) begin
			w.op = OP_NEXT_EN;
		end else if (pick < 95) begin
			w.op = OP_CLEAR;
		end else begin
			w.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
		end
		// A pool a little larger than the table gives duplicates, hits and a full table.
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			w.node_addr = ADDR_NONE;
		end else if (pick == 1) begin
			w.node_addr = ADDR_BCAST;
		end else if (pick < 5) begin
			w.node_addr = 8'($urandom);
		end else begin
			w.node_addr = 8'h40 + 8'($urandom_range(0, 21));
		end
		w.node_class = $urandom;
		w.node_flags = 8'($urandom);
		w.position = 4'($urandom);
		return w;
	endfunction

	task automatic send_word(input in_t w);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 10);
				gap = $urandom_range(0, 24);
			end
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
	endtask

	initial begin
		in_t w;
		int  counted;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups on an empty table, then illegal addresses.
		send_word(cmd_word(OP_FIND, ADDR_NONE, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_NEXT_EN, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_NTH, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_ENROLL, ADDR_NONE, 32'hFFFF_FFFF, 8'hFF, 4'hF));
		send_word(cmd_word(OP_ENROLL, ADDR_BCAST, 32'h1234_5678, 8'h01, 4'd0));
		send_word(cmd_word(OP_UNREGISTER, ADDR_BCAST, 32'h0, 8'h00, 4'd0));
		// A disabled node at the lowest address and an enabled one at the highest.
		send_word(cmd_word(OP_ENROLL, 8'h01, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_ENROLL, 8'hFE, 32'hFFFF_FFFF, 8'hFF, 4'hF));
		send_word(cmd_word(OP_ENROLL, 8'h01, 32'hA5A5_A5A5, 8'hFF, 4'd0));
		// Two polls in a row must wrap back to the one enabled node.
		send_word(cmd_word(OP_NEXT_EN, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_NEXT_EN, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_NTH, 8'h00, 32'h0, 8'h00, 4'hF));
		send_word(cmd_word(OP_NTH, 8'h00, 32'h0, 8'h00, 4'd1));
		send_word(cmd_word(OP_FIND, 8'hFE, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_UNREGISTER, 8'h01, 32'h0, 8'h00, 4'd0));
		// The freed slot zero is the lowest free slot and must be reused.
		send_word(cmd_word(OP_ENROLL, 8'h80, 32'h8000_0001, 8'h01, 4'd0));
		send_word(cmd_word(OP_NTH, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_SPARE_LO, 8'h01, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_SPARE_HI, 8'hFE, 32'hFFFF_FFFF, 8'hFF, 4'hF));
		send_word(cmd_word(OP_CLEAR, 8'h00, 32'h0, 8'h00, 4'd0));
		send_word(cmd_word(OP_FIND, 8'hFE, 32'h0, 8'h00, 4'd0));

		counted = 0;
		while (counted < RANDOM_WORDS) begin
			w = random_word();
			if (w.op != OP_SPARE_LO && w.op != OP_SPARE_HI) begin
				counted++;
			end
			send_word(w);
		end
		cmd_valid <= 1'b0;

		while (roster.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SLOTS + 8) @(posedge clk);
		if (roster.fails == 0) begin
			$display("bus_node_roster_table verification clean");
		end else begin
			$display("bus_node_roster_table verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bnr_pkg.sv
design/bnr_slot_store.sv
design/bnr_engine.sv
design/bus_node_roster_table.sv
design/bnr_checker.sv
test/testbench.sv
